[hdl/pbe_pkg.sv]
// ----------------------------------------------------------------------------
// PackBits encoder package
// Shared constants, codes, command format and a helper function.
// ----------------------------------------------------------------------------
package pbe_pkg;

   localparam int MAX_PACK_DEFAULT  = 128;
   localparam int OUT_LANES_DEFAULT = 8;

   // Pack length field; wide enough for the largest legal pack (128).
   localparam int LEN_W   = 8;
   localparam int OUT_W   = 64;
   localparam int COUNT_W = 4;

   localparam logic [7:0] TERM_BYTE = 8'd128;
   localparam logic [8:0] RUN_BASE  = 9'd257;

   localparam int CMDQ_DEPTH = 4;

   typedef enum logic [0:0] {
      ACT_DATA = 1'b0,
      ACT_END  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      MODE_UNKNOWN,
      MODE_RUN,
      MODE_LIT
   } mode_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_RUN,
      CMD_TERM
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [LEN_W-1:0]  len;
      logic              last;
   } cmd_type;

   typedef enum logic {
      F_IDLE,
      F_REMAINDER
   } front_state_type;

   typedef enum logic {
      B_HEADER,
      B_BODY
   } back_state_type;

   // Byte store pointer width: the store holds at least two entries more than
   // the largest buffered pack, so a full buffer never blocks its own flush.
   function automatic int ptr_width(input int max_pack);
      return $clog2(max_pack + 4);
   endfunction

endpackage

[hdl/pbe_if.sv]
// ----------------------------------------------------------------------------
// PackBits encoder channels
// Valid/ready channels for raw input items and packed result words.
// ----------------------------------------------------------------------------
interface pbe_req_if import pbe_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [0:0] action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface pbe_rsp_if import pbe_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OUT_W-1:0]   out_bytes;
   logic [COUNT_W-1:0] byte_count;
   logic               last_word;

   modport source (output valid, output out_bytes, output byte_count, output last_word,
                   input ready);
   modport sink   (input valid, input out_bytes, input byte_count, input last_word,
                   output ready);
endinterface

[hdl/pbe_front.sv]
// ----------------------------------------------------------------------------
// PackBits encoder front end
// Accepts items, tracks run/literal classification and issues pack commands.
// ----------------------------------------------------------------------------
module pbe_front import pbe_pkg::*; #(
   parameter int MAX_PACK = MAX_PACK_DEFAULT,
   localparam int PTR_W = ptr_width(MAX_PACK)
) (
   input  logic             clock,
   input  logic             reset,
   pbe_req_if.sink          req_ch,
   output logic             cmd_push,
   output cmd_type          cmd_data,
   input  logic             cmd_full,
   output logic             mem_wr_en,
   output logic [PTR_W-1:0] mem_wr_addr,
   output logic [7:0]       mem_wr_data,
   input  logic [PTR_W-1:0] rd_ptr
);

   localparam int BUF_DEPTH = MAX_PACK + 2;
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int MEM_DEPTH = 1 << PTR_W;

   front_state_type  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   mode_type         mode_ff, mode_in;
   logic             flush_ff, flush_in;
   logic [7:0]       last1_ff, last1_in;
   logic [7:0]       last2_ff, last2_in;
   logic [PTR_W-1:0] tail_ff, tail_in;

   logic [PTR_W-1:0] occupancy;
   logic             accept;
   logic             due_push;
   cmd_kind_type     due_kind;
   logic [LEN_W-1:0] due_len;
   logic [CNT_W-1:0] post_cnt;
   mode_type         post_mode;
   mode_type         cls_mode;
   logic             cls_flush;
   logic [LEN_W-1:0] rem_len;
   cmd_kind_type     rem_kind;

   // Bytes still held in the store, including those the back end has yet to read.
   assign occupancy    = tail_ff - rd_ptr;
   assign req_ch.ready = (state_ff == F_IDLE) && !cmd_full &&
                         (occupancy != PTR_W'(MEM_DEPTH - 1));
   assign accept       = req_ch.valid && req_ch.ready;

   // A pack closed by the previous item goes out before this item is classified.
   always_comb begin
      post_cnt  = cnt_ff;
      post_mode = mode_ff;
      due_push  = 1'b0;
      due_kind  = CMD_RUN;
      due_len   = '0;
      if (flush_ff) begin
         if (mode_ff == MODE_LIT) begin
            if (cnt_ff >= CNT_W'(3)) begin
               due_push  = 1'b1;
               due_kind  = CMD_LIT;
               due_len   = LEN_W'(cnt_ff - CNT_W'(2));
               post_cnt  = CNT_W'(2);
               post_mode = (last2_ff == last1_ff) ? MODE_RUN : MODE_LIT;
            end
         end else if (cnt_ff >= CNT_W'(2)) begin
            due_push  = 1'b1;
            due_kind  = CMD_RUN;
            due_len   = LEN_W'(cnt_ff - CNT_W'(1));
            post_cnt  = CNT_W'(1);
            post_mode = MODE_UNKNOWN;
         end
      end
   end

   always_comb begin
      cls_mode  = post_mode;
      cls_flush = 1'b0;
      if (post_cnt != '0) begin
         unique case (post_mode)
            MODE_UNKNOWN: begin
               cls_mode = (last1_ff == req_ch.data_byte) ? MODE_RUN : MODE_LIT;
            end
            MODE_RUN: begin
               cls_flush = (last1_ff != req_ch.data_byte) ||
                           (post_cnt == CNT_W'(MAX_PACK));
            end
            MODE_LIT: begin
               cls_flush = (last1_ff == req_ch.data_byte) ||
                           (post_cnt == CNT_W'(MAX_PACK + 1));
            end
            default: begin
               cls_flush = 1'b0;
            end
         endcase
      end
   end

   assign rem_len  = (cnt_ff > CNT_W'(MAX_PACK)) ? LEN_W'(MAX_PACK) : LEN_W'(cnt_ff);
   assign rem_kind = ((mode_ff == MODE_LIT) || (rem_len == LEN_W'(1))) ? CMD_LIT : CMD_RUN;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      mode_in       = mode_ff;
      flush_in      = flush_ff;
      last1_in      = last1_ff;
      last2_in      = last2_ff;
      tail_in       = tail_ff;
      cmd_push      = 1'b0;
      cmd_data.kind = CMD_TERM;
      cmd_data.len  = '0;
      cmd_data.last = 1'b1;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = tail_ff;
      mem_wr_data   = req_ch.data_byte;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cmd_push      = due_push;
               cmd_data.kind = due_kind;
               cmd_data.len  = due_len;
               cmd_data.last = (req_ch.action == ACT_DATA);
               flush_in      = 1'b0;
               if (req_ch.action == ACT_END) begin
                  cnt_in   = post_cnt;
                  mode_in  = post_mode;
                  state_in = F_REMAINDER;
               end else begin
                  mode_in  = cls_mode;
                  flush_in = cls_flush;
                  cnt_in   = post_cnt;
                  last1_in = req_ch.data_byte;
                  last2_in = last1_ff;
                  if (post_cnt < CNT_W'(BUF_DEPTH)) begin
                     cnt_in    = post_cnt + CNT_W'(1);
                     mem_wr_en = 1'b1;
                     tail_in   = tail_ff + PTR_W'(1);
                  end
               end
            end
         end
         F_REMAINDER: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               if (cnt_ff != '0) begin
                  cmd_data.kind = rem_kind;
                  cmd_data.len  = rem_len;
                  cmd_data.last = 1'b0;
                  cnt_in        = cnt_ff - CNT_W'(rem_len);
               end else begin
                  mode_in  = MODE_UNKNOWN;
                  state_in = F_IDLE;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
         mode_ff  <= MODE_UNKNOWN;
         flush_ff <= 1'b0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mode_ff  <= mode_in;
         flush_ff <= flush_in;
         tail_ff  <= tail_in;
      end
      last1_ff <= last1_in;
      last2_ff <= last2_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BUF_DEPTH))
      else $error("buffered byte count exceeds the buffer depth");

   a_flush_mode: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (mode_ff != MODE_UNKNOWN) && (cnt_ff >= CNT_W'(2)))
      else $error("pending flush without a classified pack");

   a_lit_flush: assert property (@(posedge clock) disable iff (reset)
      (flush_ff && (mode_ff == MODE_LIT)) |-> (cnt_ff >= CNT_W'(3)))
      else $error("pending literal flush holds fewer than three bytes");

endmodule

[hdl/pbe_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// PackBits encoder command queue
// Short queue of pack commands between the front end and the back end.
// ----------------------------------------------------------------------------
module pbe_cmd_fifo import pbe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    not_empty
);

   localparam int QP_W = $clog2(CMDQ_DEPTH);
   localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type         slot_ff [CMDQ_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = (count_ff == QC_W'(CMDQ_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QP_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QP_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QC_W'(do_push) - QC_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/pbe_back.sv]
// ----------------------------------------------------------------------------
// PackBits encoder back end
// Holds the byte store, turns pack commands into bytes and packs result words.
// ----------------------------------------------------------------------------
module pbe_back import pbe_pkg::*; #(
   parameter int MAX_PACK  = MAX_PACK_DEFAULT,
   parameter int OUT_LANES = OUT_LANES_DEFAULT,
   localparam int PTR_W = ptr_width(MAX_PACK)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  cmd_type          cmd_data,
   output logic             cmd_pop,
   input  logic             mem_wr_en,
   input  logic [PTR_W-1:0] mem_wr_addr,
   input  logic [7:0]       mem_wr_data,
   output logic [PTR_W-1:0] rd_ptr,
   pbe_rsp_if.source        rsp_ch
);

   localparam int MEM_DEPTH = 1 << PTR_W;
   localparam int LANE_W    = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

   logic [7:0]         byte_mem_ff [MEM_DEPTH];
   logic [7:0]         rd_data_ff;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   back_state_type     state_ff, state_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;

   logic [OUT_LANES-1:0][7:0] pk_ff, pk_in;
   logic [LANE_W-1:0]         pk_cnt_ff, pk_cnt_in;

   logic               out_valid_ff, out_valid_in;
   logic [OUT_W-1:0]   out_bytes_ff, out_bytes_in;
   logic [COUNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic               out_last_ff, out_last_in;

   logic [7:0]                hdr_byte;
   logic [8:0]                run_hdr;
   logic                      b_valid;
   logic [7:0]                b_byte;
   logic                      b_eoi;
   logic                      body_end;
   logic                      word_done;
   logic                      stall;
   logic                      advance;
   logic [OUT_LANES-1:0][7:0] merged;

   assign rd_ptr = rd_ptr_ff;
   assign run_hdr = RUN_BASE - 9'(cmd_data.len);

   always_comb begin
      unique case (cmd_data.kind)
         CMD_LIT: hdr_byte = 8'(cmd_data.len - LEN_W'(1));
         CMD_RUN: hdr_byte = run_hdr[7:0];
         default: hdr_byte = TERM_BYTE;
      endcase
   end

   assign body_end = (cmd_data.kind == CMD_RUN) || (rem_ff == LEN_W'(1));

   always_comb begin
      unique case (state_ff)
         B_HEADER: begin
            b_valid = cmd_valid;
            b_byte  = hdr_byte;
            b_eoi   = (cmd_data.kind == CMD_TERM) && cmd_data.last;
         end
         B_BODY: begin
            b_valid = 1'b1;
            b_byte  = rd_data_ff;
            b_eoi   = body_end && cmd_data.last;
         end
         default: begin
            b_valid = 1'b0;
            b_byte  = rd_data_ff;
            b_eoi   = 1'b0;
         end
      endcase
   end

   // A byte that completes a word needs room in the output register.
   assign word_done = b_valid && ((pk_cnt_ff == LANE_W'(OUT_LANES - 1)) || b_eoi);
   assign stall     = word_done && out_valid_ff && !rsp_ch.ready;
   assign advance   = b_valid && !stall;

   always_comb begin
      for (int i = 0; i < OUT_LANES; i++) begin
         merged[i] = (LANE_W'(i) == pk_cnt_ff) ? b_byte : pk_ff[i];
      end
   end

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      rd_ptr_in = rd_ptr_ff;
      cmd_pop   = 1'b0;
      if (advance) begin
         unique case (state_ff)
            B_HEADER: begin
               if (cmd_data.kind == CMD_TERM) begin
                  cmd_pop = 1'b1;
               end else begin
                  state_in = B_BODY;
                  rem_in   = (cmd_data.kind == CMD_LIT) ? cmd_data.len : LEN_W'(1);
               end
            end
            B_BODY: begin
               if (cmd_data.kind == CMD_RUN) begin
                  rd_ptr_in = rd_ptr_ff + PTR_W'(cmd_data.len);
               end else begin
                  rd_ptr_in = rd_ptr_ff + PTR_W'(1);
               end
               rem_in = rem_ff - LEN_W'(1);
               if (body_end) begin
                  cmd_pop  = 1'b1;
                  state_in = B_HEADER;
               end
            end
            default: begin
               state_in = B_HEADER;
            end
         endcase
      end
   end

   always_comb begin
      pk_in        = pk_ff;
      pk_cnt_in    = pk_cnt_ff;
      out_valid_in = out_valid_ff;
      out_bytes_in = out_bytes_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance && word_done) begin
         out_valid_in = 1'b1;
         out_bytes_in = OUT_W'(merged);
         out_cnt_in   = COUNT_W'(pk_cnt_ff) + COUNT_W'(1);
         out_last_in  = b_eoi;
         pk_in        = '0;
         pk_cnt_in    = '0;
      end else if (advance) begin
         pk_in     = merged;
         pk_cnt_in = pk_cnt_ff + LANE_W'(1);
      end
   end

   // The read address follows the next pointer, so the read data always
   // matches the current head of the store.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         byte_mem_ff[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= byte_mem_ff[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_HEADER;
         rd_ptr_ff    <= '0;
         pk_ff        <= '0;
         pk_cnt_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         pk_ff        <= pk_in;
         pk_cnt_ff    <= pk_cnt_in;
         out_valid_ff <= out_valid_in;
      end
      rem_ff       <= rem_in;
      out_bytes_ff <= out_bytes_in;
      out_cnt_ff   <= out_cnt_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.out_bytes  = out_bytes_ff;
   assign rsp_ch.byte_count = out_cnt_ff;
   assign rsp_ch.last_word  = out_last_ff;

   a_body_has_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_BODY) |-> cmd_valid)
      else $error("pack body in progress without a queued command");

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_cnt_ff != '0) && (out_cnt_ff <= COUNT_W'(OUT_LANES)))
      else $error("result word byte count out of range");

   a_item_end_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && b_eoi) |=> (pk_cnt_ff == '0))
      else $error("packer not empty after the last byte of an item");

endmodule

[hdl/packbits_encoder_top.sv]
// ----------------------------------------------------------------------------
// PackBits encoder top level
// Byte-stream run-length encoder with packed multi-byte result words.
// ----------------------------------------------------------------------------
// Usage: req_ch carries one item per handshake, either a data byte (action 0)
// or an end-of-stream marker (action 1). rsp_ch returns words of up to
// OUT_LANES encoded bytes, first byte in the low bits, with byte_count and a
// last_word flag on the final word caused by each input item. A data item that
// closes nothing produces no words; an end item always produces at least the
// terminator byte 128 and returns the encoder to its idle state.
// Throughput: the front end takes one data item per clock while the command
// queue and the 2**PTR_W-entry byte store have room. After an end item,
// req_ch.ready stays low while the remainder packs, at most two, and the
// terminator are queued. While a command is queued and the output register
// is not stalled, the back end emits one encoded byte per clock from a single
// store read port: a literal pack of n bytes is a header byte followed by
// those n bytes, a run pack a header byte followed by the repeated byte.
// Reset: synchronous; the byte store is not cleared and needs no warm-up.
// When rsp_ch stalls, the output register holds its word, the back end stops
// at the next completed word, and the front end keeps taking items until the
// queue or the store fills.
// ----------------------------------------------------------------------------
module packbits_encoder_top import pbe_pkg::*; #(
   parameter int MAX_PACK  = MAX_PACK_DEFAULT,
   parameter int OUT_LANES = OUT_LANES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   pbe_req_if.sink   req_ch,
   pbe_rsp_if.source rsp_ch
);

   localparam int PTR_W = ptr_width(MAX_PACK);

   // Front end to queue.
   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_full;

   // Queue to back end.
   logic    cmd_pop;
   cmd_type cmd_out;
   logic    cmd_valid;

   // Byte store write port (front) and read head (back).
   logic             mem_wr_en;
   logic [PTR_W-1:0] mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic [PTR_W-1:0] rd_ptr;

   // The front end classifies each byte, appends it to the store and issues a
   // command for every pack that closes.
   pbe_front #(
      .MAX_PACK (MAX_PACK)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in),
      .cmd_full    (cmd_full),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .rd_ptr      (rd_ptr)
   );

   // Commands wait here so that output stalls do not stop input intake at once.
   pbe_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .not_empty (cmd_valid)
   );

   // The back end reads the bytes named by each command and packs the words.
   pbe_back #(
      .MAX_PACK  (MAX_PACK),
      .OUT_LANES (OUT_LANES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_out),
      .cmd_pop     (cmd_pop),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .rd_ptr      (rd_ptr),
      .rsp_ch      (rsp_ch)
   );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PackBits encoder testbench
// Drives byte streams and end markers into the encoder, predicts each packed
// result word with an in-bench run-length encoder, and checks every word
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import pbe_pkg::*;

   localparam int MAX_PACK       = MAX_PACK_DEFAULT;
   localparam int LANES          = OUT_LANES_DEFAULT;
   localparam int HELD_DEPTH     = MAX_PACK + 2;
   localparam int PHASE_ITEMS    = 20;
   localparam int TAIL_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ERROR_LIMIT    = 200;

   // Shapes of byte segments used to build random streams.
   typedef enum int {
      SEG_RUN,
      SEG_LITERAL,
      SEG_REPEATS,
      SEG_NOISE
   } seg_kind_type;

   typedef struct {
      action_type act;
      logic [7:0] val;
   } stim_item_type;

   typedef struct {
      logic [OUT_W-1:0]   data;
      logic [COUNT_W-1:0] count;
      logic               last;
   } coded_word_type;

   logic clock;
   logic reset;

   pbe_req_if req_if ();
   pbe_rsp_if rsp_if ();

   packbits_encoder_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   // Items waiting to be driven, and the words the encoder must still produce.
   stim_item_type  pending_items[$];
   coded_word_type expected_words[$];

   // Shadow encoder state: buffered bytes, their count, the pack mode and the
   // flag that says a closed pack goes out at the start of the next item.
   logic [7:0] held_bytes[HELD_DEPTH];
   int         held_count;
   mode_type   held_mode;
   logic       close_due;
   logic [7:0] coded[$];

   int error_count;
   int queued_items;
   int word_index;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   // -------------------------------------------------------------------------
   // Clock and reset. Reset is synchronous and asserted once.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.action    = ACT_DATA;
      req_if.data_byte = 8'h00;
      rsp_if.ready     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // -------------------------------------------------------------------------
   // Shadow encoder. It mirrors the block item by item: a pack closed by one
   // data item is emitted when the next item arrives, and an end item emits
   // any closed pack, then the remainder, then the terminator byte.
   // -------------------------------------------------------------------------
   function automatic void drop_held(int n);
      if (n >= held_count) begin
         held_count = 0;
         return;
      end
      for (int i = 0; i < held_count - n; i++) begin
         held_bytes[i] = held_bytes[i + n];
      end
      held_count -= n;
   endfunction

   // A literal pack is its length minus one followed by the bytes themselves.
   function automatic void pack_literal(int n);
      coded.insert(coded.size(), 8'(n - 1));
      for (int i = 0; i < n && i < held_count; i++) begin
         coded.insert(coded.size(), held_bytes[i]);
      end
      drop_held(n);
   endfunction

   // A run pack is 257 minus its length followed by the repeated byte.
   function automatic void pack_run(int n);
      coded.insert(coded.size(), 8'(RUN_BASE - 9'(n)));
      coded.insert(coded.size(), held_bytes[0]);
      drop_held(n);
   endfunction

   function automatic void encode_item(action_type act, logic [7:0] val);
      logic [7:0]     last_held;
      coded_word_type word;
      int             pos;
      int             n;

      coded.delete();
      if (close_due) begin
         if (held_mode == MODE_LIT) begin
            // The two newest bytes stay behind and decide the next mode.
            if (held_count >= 3) begin
               pack_literal(held_count - 2);
               held_mode = (held_bytes[held_count - 1] == held_bytes[0]) ? MODE_RUN
                                                                         : MODE_LIT;
            end
         end else if (held_count >= 2) begin
            // Only the newest byte, the one that broke the run, stays behind.
            pack_run(held_count - 1);
            held_mode = MODE_UNKNOWN;
         end
         close_due = 1'b0;
      end

      if (act == ACT_END) begin
         // Literal remainders split at MAX_PACK; a lone byte is a literal.
         while (held_count > 0) begin
            n = (held_count > MAX_PACK) ? MAX_PACK : held_count;
            if (held_mode == MODE_LIT || n == 1) begin
               pack_literal(n);
            end else begin
               pack_run(n);
            end
         end
         coded.insert(coded.size(), TERM_BYTE);
         held_count = 0;
         held_mode  = MODE_UNKNOWN;
         close_due  = 1'b0;
      end else begin
         if (held_count > 0) begin
            last_held = held_bytes[held_count - 1];
            case (held_mode)
               MODE_UNKNOWN: begin
                  held_mode = (last_held == val) ? MODE_RUN : MODE_LIT;
               end
               MODE_RUN: begin
                  close_due = (last_held != val) || (held_count == MAX_PACK);
               end
               default: begin
                  close_due = (last_held == val) || (held_count == MAX_PACK + 1);
               end
            endcase
         end
         if (held_count < HELD_DEPTH) begin
            held_bytes[held_count] = val;
            held_count++;
         end
      end

      // Pack the emitted bytes into words, first byte in the low lane.
      pos = 0;
      while (pos < coded.size()) begin
         n = coded.size() - pos;
         if (n > LANES) n = LANES;
         word.data = '0;
         for (int i = 0; i < n; i++) begin
            word.data[8*i +: 8] = coded[pos + i];
         end
         pos += n;
         word.count = COUNT_W'(n);
         word.last  = (pos >= coded.size());
         expected_words.insert(expected_words.size(), word);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Mismatch reporting. Every failure prints one line and is counted.
   // -------------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic bit roll(int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // -------------------------------------------------------------------------
   // Driver. An item is held until it is accepted; the shadow encoder runs on
   // the accepted item at that same edge. Each signal gets one assignment per
   // edge, so a valid that stays high for the next item is never pulsed low.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      stim_item_type fresh;
      logic          holding;

      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         holding = req_if.valid && !req_if.ready;
         if (req_if.valid && req_if.ready) begin
            encode_item(action_type'(req_if.action), req_if.data_byte);
         end
         if (!holding) begin
            if (pending_items.size() > 0 && !roll(send_idle_pct)) begin
               fresh = pending_items.pop_front();
               req_if.valid     <= 1'b1;
               req_if.action    <= fresh.act;
               req_if.data_byte <= fresh.val;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. Each accepted word is compared with the oldest expected word.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      coded_word_type want;

      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word %0d not expected: bytes %h count %0d last %b",
                                         word_index, rsp_if.out_bytes, rsp_if.byte_count,
                                         rsp_if.last_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_if.out_bytes !== want.data) begin
                  report_mismatch($sformatf("word %0d out_bytes %h, expected %h",
                                            word_index, rsp_if.out_bytes, want.data));
               end
               if (rsp_if.byte_count !== want.count) begin
                  report_mismatch($sformatf("word %0d byte_count %0d, expected %0d",
                                            word_index, rsp_if.byte_count, want.count));
               end
               if (rsp_if.last_word !== want.last) begin
                  report_mismatch($sformatf("word %0d last_word %b, expected %b",
                                            word_index, rsp_if.last_word, want.last));
               end
            end
            word_index++;
         end
         rsp_if.ready <= !roll(recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: too long without any item moving on either channel, or a flood
   // of mismatches from a block that keeps emitting words, ends the run.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT || error_count >= ERROR_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus building blocks.
   // -------------------------------------------------------------------------
   task automatic queue_data(logic [7:0] val);
      stim_item_type it;
      it.act = ACT_DATA;
      it.val = val;
      pending_items.insert(pending_items.size(), it);
      queued_items++;
   endtask

   // The byte field of an end item is ignored by the block, so it is random.
   task automatic queue_end();
      stim_item_type it;
      it.act = ACT_END;
      it.val = 8'($urandom_range(255, 0));
      pending_items.insert(pending_items.size(), it);
      queued_items++;
   endtask

   task automatic add_run(logic [7:0] val, int len);
      repeat (len) queue_data(val);
   endtask

   // Literal stretch: no two neighbors are equal.
   task automatic add_literal(int len);
      logic [7:0] prev;
      logic [7:0] val;
      prev = 8'($urandom_range(255, 0));
      repeat (len) begin
         val = 8'($urandom_range(255, 0));
         if (val == prev) val = val + 8'd1;
         queue_data(val);
         prev = val;
      end
   endtask

   // Noise from a tiny alphabet collides often and mixes short runs and
   // literals; full-range noise rarely repeats.
   task automatic add_noise(int len, bit narrow);
      repeat (len) begin
         if (narrow) begin
            queue_data(8'($urandom_range(3, 0)));
         end else begin
            queue_data(8'($urandom_range(255, 0)));
         end
      end
   endtask

   // One stream: up to four segments of random shape, closed by an end item.
   // A stream with no segment is a bare end marker.
   task automatic add_random_stream();
      int           segments;
      seg_kind_type kind;
      segments = $urandom_range(4, 0);
      repeat (segments) begin
         kind = seg_kind_type'($urandom_range(SEG_NOISE, SEG_RUN));
         case (kind)
            SEG_RUN:     add_run(8'($urandom_range(255, 0)), $urandom_range(10, 2));
            SEG_LITERAL: add_literal($urandom_range(10, 1));
            SEG_REPEATS: add_noise($urandom_range(8, 1), 1'b1);
            default:     add_noise($urandom_range(6, 1), 1'b0);
         endcase
      end
      queue_end();
   endtask

   // Directed cases: empty stream, a single byte, extreme byte values, run and
   // literal remainders, a run closed by a differing byte just before the end,
   // and a literal closed by equal neighbors in the middle of a stream.
   task automatic add_directed();
      queue_end();
      queue_data(8'h00);
      queue_end();
      add_run(8'hFF, 2);
      queue_end();
      queue_data(8'h01);
      queue_data(8'h02);
      queue_data(8'h03);
      queue_end();
      add_run(8'h05, 3);
      queue_data(8'h07);
      queue_end();
      queue_data(8'h10);
      queue_data(8'h20);
      add_run(8'h30, 3);
      queue_end();
      queue_data(8'hAA);
      queue_data(8'h55);
      queue_end();
   endtask

   // -------------------------------------------------------------------------
   // Test sequence. Four idling phases: none, sender idle most cycles,
   // receiver stalling most cycles, and both idling about a third of the time.
   // The first phase opens with the directed cases; the second carries one
   // long segment around the MAX_PACK limit, either a run or a literal. Between
   // phases the sender holds off until every expected word has arrived.
   // -------------------------------------------------------------------------
   initial begin
      int send_pct_by_phase[4];
      int recv_pct_by_phase[4];
      int phase_start;

      send_pct_by_phase = '{0, 87, 0, 31};
      recv_pct_by_phase = '{0, 0, 87, 31};
      error_count    = 0;
      queued_items   = 0;
      word_index     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      held_count     = 0;
      held_mode      = MODE_UNKNOWN;
      close_due      = 1'b0;

      @(negedge reset);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_pct_by_phase[ph];
         recv_stall_pct = recv_pct_by_phase[ph];
         phase_start    = queued_items;
         if (ph == 0) begin
            add_directed();
         end
         if (ph == 1) begin
            // A run reaching MAX_PACK closes there and longer runs split; a
            // literal of MAX_PACK + 1 bytes ends as two packs and longer ones
            // close on the buffer limit before the end arrives.
            if ($urandom_range(1, 0) == 0) begin
               add_run(8'($urandom_range(255, 0)),
                       $urandom_range(MAX_PACK + 3, MAX_PACK - 1));
            end else begin
               add_literal($urandom_range(MAX_PACK + 4, MAX_PACK - 1));
            end
            add_random_stream();
         end
         while (queued_items - phase_start < PHASE_ITEMS) begin
            add_random_stream();
         end
         while (pending_items.size() != 0 || req_if.valid || expected_words.size() != 0) begin
            @(posedge clock);
         end
      end

      // Let any stray word surface before judging the run.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
